// File: src/dtd_pkg.sv
// Shared types, reset constants and the knob level conversion for the dimmer.
package dtd_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_DEBOUNCE_RELOAD = 2'd0;
   localparam logic [1:0] CSR_DEADBAND        = 2'd1;
   localparam logic [1:0] CSR_START_COMPARE   = 2'd2;

   // Register reset values.
   localparam logic [7:0] RESET_DEBOUNCE_RELOAD = 8'd10;
   localparam logic [9:0] RESET_DEADBAND        = 10'd15;
   localparam logic [9:0] RESET_START_COMPARE   = 10'd50;

   // State reset values.
   localparam logic [9:0] RESET_DUTY_LEVEL   = 10'd50;
   localparam logic [7:0] RESET_STABLE_COUNT = 8'd10;

   localparam logic [6:0] KNOB_SCALE = 7'd99;
   localparam logic [3:0] LEVEL_STEP = 4'd10;

   typedef struct packed {
      logic       debounce_reload_we;
      logic [7:0] debounce_reload;
      logic       advance;
      logic       button_level;
   } debounce_ctrl_type;

   // Level 10*((99*s)/255+1). The divide by 255 uses (x + (x>>8) + 1) >> 8,
   // exact for x below 65535; here x stays below 25246.
   function automatic logic [9:0] knob_level(input logic [7:0] s);
      logic [14:0] prod;
      logic [15:0] sum;
      logic [6:0]  quot;
      logic [13:0] scaled;
      prod   = 15'(s) * 15'(KNOB_SCALE);
      sum    = 16'(prod) + 16'(prod[14:8]) + 16'd1;
      quot   = sum[14:8];
      scaled = (14'(quot) + 14'd1) * 14'(LEVEL_STEP);
      return scaled[9:0];
   endfunction

endpackage

// File: src/dtd_debounce.sv
// Button debouncer: arm on a low level, count equal levels, judge release.
module dtd_debounce (
   input  logic                       clock,
   input  logic                       reset,
   input  dtd_pkg::debounce_ctrl_type ctrl,
   output logic                       press
);

   logic [7:0] reload_val_ff, reload_val_in;
   logic       armed_ff, armed_in;
   logic       prev_ff, prev_in;
   logic [7:0] count_ff, count_in;

   always_comb begin
      reload_val_in = ctrl.debounce_reload_we ? ctrl.debounce_reload : reload_val_ff;
      armed_in      = armed_ff;
      prev_in       = prev_ff;
      count_in      = count_ff;
      press         = 1'b0;
      if (ctrl.advance) begin
         if (!armed_ff) begin
            if (!ctrl.button_level) begin
               armed_in = 1'b1;
               prev_in  = 1'b0;
            end
         end else if (count_ff == 8'd0) begin
            // Judge the level: high means released, a completed press.
            armed_in = 1'b0;
            count_in = reload_val_ff;
            prev_in  = 1'b1;
            if (ctrl.button_level) begin
               press = 1'b1;
            end else begin
               prev_in = 1'b0;
            end
         end else if (ctrl.button_level == prev_ff) begin
            count_in = count_ff - 8'd1;
         end else begin
            prev_in = ctrl.button_level;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_val_ff <= dtd_pkg::RESET_DEBOUNCE_RELOAD;
         armed_ff      <= 1'b0;
         prev_ff       <= 1'b1;
         count_ff      <= dtd_pkg::RESET_STABLE_COUNT;
      end else begin
         reload_val_ff <= reload_val_in;
         armed_ff      <= armed_in;
         prev_ff       <= prev_in;
         count_ff      <= count_in;
      end
   end

endmodule

// File: src/debounced_toggle_dimmer.sv
// Top level: input register, lamp and duty logic, debouncer, result register.
// An accepted item waits in the input register until the result register frees.
// Throughput: one item per cycle unless the result side stalls; the input and
// result registers form a two-stage pipe, and state updates as each item moves
// to the result register.
// Reset (synchronous, active high) empties both stages, loads the register
// defaults and returns the lamp, duty and debouncer state to their reset values.
module debounced_toggle_dimmer (
   input  logic       clock,
   input  logic       reset,
   // input items
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_button_level,
   input  logic       req_sample_valid,
   input  logic [7:0] req_adc_sample,
   // result items
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_lamp_on,
   output logic [9:0] rsp_pwm_compare,
   output logic       rsp_press_seen,
   // configuration writes
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [9:0] csr_data
);

   // Input stage.
   logic       in_valid_ff, in_valid_in;
   logic       in_level_ff, in_level_in;
   logic       in_sample_valid_ff, in_sample_valid_in;
   logic [7:0] in_sample_ff, in_sample_in;

   // Result stage.
   logic       out_valid_ff, out_valid_in;
   logic       out_lamp_ff, out_lamp_in;
   logic [9:0] out_compare_ff, out_compare_in;
   logic       out_press_ff, out_press_in;

   // Configuration.
   logic [9:0] deadband_ff, deadband_in;
   logic [9:0] start_compare_ff, start_compare_in;

   // Lamp state.
   logic       lamp_ff, lamp_in;
   logic [9:0] duty_ff, duty_in;
   logic [9:0] latched_ff, latched_in;
   logic [9:0] compare_ff, compare_in;

   logic       advance;
   logic       press;
   logic [9:0] latched_now;
   logic [10:0] upper_bound;
   logic [9:0]  lower_bound;
   logic        update;
   dtd_pkg::debounce_ctrl_type deb_ctrl;

   // Move the held item into the result register when that register frees.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_valid_in        = in_valid_ff;
      in_level_in        = in_level_ff;
      in_sample_valid_in = in_sample_valid_ff;
      in_sample_in       = in_sample_ff;
      if (!req_stall) begin
         in_valid_in        = req_valid;
         in_level_in        = req_button_level;
         in_sample_valid_in = req_sample_valid;
         in_sample_in       = req_adc_sample;
      end
   end

   always_comb begin
      deadband_in      = deadband_ff;
      start_compare_in = start_compare_ff;
      if (csr_write && csr_index == dtd_pkg::CSR_DEADBAND) begin
         deadband_in = csr_data;
      end
      if (csr_write && csr_index == dtd_pkg::CSR_START_COMPARE) begin
         start_compare_in = csr_data;
      end
   end

   always_comb begin
      deb_ctrl.debounce_reload_we = csr_write && csr_index == dtd_pkg::CSR_DEBOUNCE_RELOAD;
      deb_ctrl.debounce_reload    = csr_data[7:0];
      deb_ctrl.advance            = advance;
      deb_ctrl.button_level       = in_level_ff;
   end

   dtd_debounce u_debounce (
      .clock (clock),
      .reset (reset),
      .ctrl  (deb_ctrl),
      .press (press)
   );

   // Latch the knob level only while the lamp is on, from the state at tick start.
   assign latched_now = (lamp_ff && in_sample_valid_ff) ?
                        dtd_pkg::knob_level(in_sample_ff) : latched_ff;

   // Deadband window; below the deadband the duty always follows.
   assign upper_bound = 11'(duty_ff) + 11'(deadband_ff);
   assign lower_bound = duty_ff - deadband_ff;
   assign update      = (duty_ff < deadband_ff) ||
                        (11'(latched_now) > upper_bound) ||
                        (latched_now < lower_bound);

   always_comb begin
      lamp_in    = lamp_ff;
      duty_in    = duty_ff;
      latched_in = latched_ff;
      compare_in = compare_ff;
      if (advance) begin
         latched_in = latched_now;
         if (lamp_ff && update) begin
            duty_in    = latched_now;
            compare_in = latched_now;
         end
         // Toggle the lamp on a press: on loads the start value, off clears.
         if (press) begin
            lamp_in    = !lamp_ff;
            compare_in = lamp_ff ? 10'd0 : start_compare_ff;
         end
      end
   end

   always_comb begin
      out_valid_in   = out_valid_ff;
      out_lamp_in    = out_lamp_ff;
      out_compare_in = out_compare_ff;
      out_press_in   = out_press_ff;
      if (!out_valid_ff || !rsp_stall) begin
         out_valid_in   = advance;
         out_lamp_in    = lamp_in;
         out_compare_in = compare_in;
         out_press_in   = press;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         deadband_ff      <= dtd_pkg::RESET_DEADBAND;
         start_compare_ff <= dtd_pkg::RESET_START_COMPARE;
         lamp_ff          <= 1'b0;
         duty_ff          <= dtd_pkg::RESET_DUTY_LEVEL;
         latched_ff       <= 10'd0;
         compare_ff       <= 10'd0;
      end else begin
         in_valid_ff      <= in_valid_in;
         out_valid_ff     <= out_valid_in;
         deadband_ff      <= deadband_in;
         start_compare_ff <= start_compare_in;
         lamp_ff          <= lamp_in;
         duty_ff          <= duty_in;
         latched_ff       <= latched_in;
         compare_ff       <= compare_in;
      end
   end

   // Payload registers hold without reset.
   always_ff @(posedge clock) begin
      in_level_ff        <= in_level_in;
      in_sample_valid_ff <= in_sample_valid_in;
      in_sample_ff       <= in_sample_in;
      out_lamp_ff        <= out_lamp_in;
      out_compare_ff     <= out_compare_in;
      out_press_ff       <= out_press_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_lamp_on     = out_lamp_ff;
   assign rsp_pwm_compare = out_compare_ff;
   assign rsp_press_seen  = out_press_ff;

endmodule
